// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/hsp_pkg.sv =====
// package for the hall speed pid controller: widths, register indexes, microcode
package hsp_pkg;

  // field and bus widths
  localparam int CmdW    = 16;
  localparam int InDataW = 16;
  localparam int OutDataW = 72;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;
  localparam int ProdW   = 36;
  localparam int StepW   = 4;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegGainP     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIntLimit  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDeadZone  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPeriod    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegReverse   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegDirMode   = 3'd7;

  // request kinds carried in tuser
  localparam logic ReqHall = 1'b0;

  // reciprocals for division by constants
  localparam logic [17:0] Recip60   = 18'd34953;      // x/60 = (x*m) >> 21, x <= 2^15
  localparam logic [17:0] Recip100  = 18'd83887;      // x/100 = (x*m) >> 23, x < 2^16
  localparam logic [29:0] Recip10k  = 30'd879609303;  // x/10000 = (x*m) >> 43, x < 2^29

  // multiplier operand selection
  typedef enum logic [2:0] {
    MulNone,
    MulCmd60,
    MulErrP,
    MulIntI,
    MulDerrD,
    MulPm1100,
    MulDrvPm1
  } mul_sel_e;

  // accumulator operation
  typedef enum logic [1:0] {
    AccHold,
    AccLoad,
    AccAdd
  } acc_op_e;

  // datapath register update
  typedef enum logic [3:0] {
    DpNop,
    DpSpeed,
    DpTarget,
    DpError,
    DpIntegral,
    DpLastErr,
    DpResult,
    DpDrive,
    DpEmit
  } dp_op_e;

  // one microcode word
  typedef struct packed {
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    dp_op_e   dp_op;
    logic     jmp_hall;
    logic     last;
  } ctrl_word_t;

  // control program, one word per step
  function automatic ctrl_word_t ucode_word(input logic [StepW-1:0] step);
    ctrl_word_t cw;
    cw = '{mul_sel: MulNone, acc_op: AccHold, dp_op: DpNop, jmp_hall: 1'b0, last: 1'b0};
    case (step)
      4'd0: cw = '{mul_sel: MulCmd60, acc_op: AccHold, dp_op: DpSpeed,
                   jmp_hall: 1'b1, last: 1'b0};
      4'd1: cw.dp_op = DpTarget;
      4'd2: cw.dp_op = DpError;
      4'd3: begin
        cw.mul_sel = MulErrP;
        cw.dp_op   = DpIntegral;
      end
      4'd4: begin
        cw.mul_sel = MulIntI;
        cw.acc_op  = AccLoad;
      end
      4'd5: begin
        cw.mul_sel = MulDerrD;
        cw.acc_op  = AccAdd;
        cw.dp_op   = DpLastErr;
      end
      4'd6: begin
        cw.mul_sel = MulPm1100;
        cw.acc_op  = AccAdd;
      end
      4'd7: cw.dp_op = DpResult;
      4'd8: cw.dp_op = DpDrive;
      4'd9: cw.mul_sel = MulDrvPm1;
      4'd10: begin
        cw.dp_op = DpEmit;
        cw.last  = 1'b1;
      end
      default: cw.last = 1'b1;
    endcase
    return cw;
  endfunction

endpackage

// ===== sv/hsp_seq.sv =====
// microcode sequencer: step counter, program table and item handshake control
module hsp_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                is_hall_i,
  input  logic                out_free_i,
  output logic                busy_o,
  output logic                step_en_o,
  output hsp_pkg::ctrl_word_t cw_o
);
  import hsp_pkg::*;

  logic             busy_q;
  logic [StepW-1:0] step_q;

  // current control word
  assign cw_o      = ucode_word(step_q);
  assign busy_o    = busy_q;
  // the final step waits for a free output register
  assign step_en_o = busy_q && !(cw_o.last && !out_free_i);

  // step counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (step_en_o) begin
      if ((cw_o.jmp_hall && is_hall_i) || cw_o.last) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

endmodule

// ===== sv/hall_speed_pid_pwm.sv =====
// top level: hall odometer, pid loop and pwm compare datapath under microcode control
//
// channel   dir  tdata fields (low bit up)                          tuser
// s_axis    in   speed_cmd                                          req_type
// m_axis    out  duty_compare, dir_compare, dir_level,              -
//                measured_speed, pid_output
// cfg       in   write enable, register index, write data           -
//
// a hall edge is accepted, then updates the odometer; a control tick is accepted,
// then runs 11 microcode steps through one shared 18x18 multiplier.
// the last step waits while the previous result is still held on m_axis.
// a new item is accepted while a result waits, once the sequencer is idle.
// reset clears the odometer, integral, last error and loads register defaults.
module hall_speed_pid_pwm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hsp_pkg::InDataW-1:0]   s_axis_tdata,   // speed_cmd
  input  logic                          s_axis_tuser,   // req_type
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // duty_compare, dir_compare, dir_level, measured_speed, pid_output, zero pad
  output logic [hsp_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [hsp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hsp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import hsp_pkg::*;

  // configuration registers
  logic [15:0] gain_p_q, gain_i_q, gain_d_q, period_q;
  logic [14:0] int_limit_q;
  logic [12:0] dead_zone_q;
  logic        reverse_q, dir_mode_q;

  // item and loop state
  logic [CmdW-1:0]  cmd_q;
  logic             req_q;
  logic [31:0]      odo_q, last_odo_q;
  logic [15:0]      speed_q;
  logic [11:0]      target_q;
  logic [15:0]      err_q, integral_q, last_err_q;
  logic signed [ProdW-1:0] prod_q, acc_q;
  logic [15:0]      res_q, dcmp_q;
  logic [12:0]      drive_q;

  // output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  // sequencer
  ctrl_word_t cw;
  logic       busy, step_en, accept, out_free;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  hsp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .is_hall_i  (req_q == ReqHall),
    .out_free_i (out_free),
    .busy_o     (busy),
    .step_en_o  (step_en),
    .cw_o       (cw)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= 16'd128;
      gain_i_q    <= 16'd512;
      gain_d_q    <= 16'd0;
      int_limit_q <= 15'd150;
      dead_zone_q <= 13'd40;
      period_q    <= 16'd1000;
      reverse_q   <= 1'b0;
      dir_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegGainP:    gain_p_q    <= cfg_data_i;
        RegGainI:    gain_i_q    <= cfg_data_i;
        RegGainD:    gain_d_q    <= cfg_data_i;
        RegIntLimit: int_limit_q <= cfg_data_i[14:0];
        RegDeadZone: dead_zone_q <= cfg_data_i[12:0];
        RegPeriod:   period_q    <= cfg_data_i;
        RegReverse:  reverse_q   <= cfg_data_i[0];
        RegDirMode:  dir_mode_q  <= cfg_data_i[0];
      endcase
    end
  end

  // shared operands
  logic [16:0] abs_cmd;
  logic [16:0] derr;
  logic [15:0] pm1;
  assign abs_cmd = cmd_q[15] ? (17'd0 - {1'b1, cmd_q}) : {1'b0, cmd_q};
  assign derr    = {err_q[15], err_q} - {last_err_q[15], last_err_q};
  assign pm1     = (period_q == 16'd0) ? 16'd0 : period_q - 16'd1;

  // shared multiplier operand mux
  logic signed [17:0] mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cw.mul_sel)
      MulNone: begin
        mul_a = '0;
        mul_b = '0;
      end
      MulCmd60: begin
        mul_a = {1'b0, abs_cmd};
        mul_b = Recip60;
      end
      MulErrP: begin
        mul_a = {{2{err_q[15]}}, err_q};
        mul_b = {2'b00, gain_p_q};
      end
      MulIntI: begin
        mul_a = {{2{integral_q[15]}}, integral_q};
        mul_b = {2'b00, gain_i_q};
      end
      MulDerrD: begin
        mul_a = {derr[16], derr};
        mul_b = {2'b00, gain_d_q};
      end
      MulPm1100: begin
        mul_a = {2'b00, pm1};
        mul_b = Recip100;
      end
      MulDrvPm1: begin
        mul_a = {5'b00000, drive_q};
        mul_b = {2'b00, pm1};
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // speed from odometer difference, saturated
  logic [31:0] odo_diff, odo_mag;
  logic [15:0] speed_d;
  assign odo_diff = odo_q - last_odo_q;
  assign odo_mag  = odo_diff[31] ? (32'd0 - odo_diff) : odo_diff;
  assign speed_d  = (odo_mag[31:16] != 16'd0) ? 16'hffff : odo_mag[15:0];

  // target = 100 - cmd/60
  logic [9:0]  tgt_q60;
  logic [11:0] target_d;
  assign tgt_q60  = prod_q[30:21];
  assign target_d = cmd_q[15] ? (12'd100 + {2'b00, tgt_q60}) : (12'd100 - {2'b00, tgt_q60});

  // error, saturated to 16 bits
  logic [17:0] err_wide;
  logic [15:0] err_d;
  assign err_wide = {{6{target_q[11]}}, target_q} - {2'b00, speed_q};
  always_comb begin
    if (err_wide[17:15] == 3'b000 || err_wide[17:15] == 3'b111) begin
      err_d = err_wide[15:0];
    end else if (err_wide[17]) begin
      err_d = 16'h8000;
    end else begin
      err_d = 16'h7fff;
    end
  end

  // integral with clamp and decay at rest
  logic [16:0] int_sum, lim_pos, lim_neg, int_clamp;
  logic [15:0] integral_d;
  assign int_sum = {integral_q[15], integral_q} + {err_q[15], err_q};
  assign lim_pos = {2'b00, int_limit_q};
  assign lim_neg = 17'd0 - lim_pos;
  always_comb begin
    priority if ($signed(int_sum) > $signed(lim_pos)) begin
      int_clamp = lim_pos;
    end else if ($signed(int_sum) < $signed(lim_neg)) begin
      int_clamp = lim_neg;
    end else begin
      int_clamp = int_sum;
    end
    integral_d = int_clamp[15:0];
    if (target_q == 12'd0 && speed_q == 16'd0) begin
      if ($signed(int_clamp[15:0]) > 16'sd0) begin
        integral_d = int_clamp[15:0] - 16'd1;
      end else if ($signed(int_clamp[15:0]) < 16'sd0) begin
        integral_d = int_clamp[15:0] + 16'd1;
      end
    end
  end

  // result: divide by 256 toward zero, then cap
  logic [ProdW-1:0]  acc_adj;
  logic signed [27:0] res_div;
  logic [15:0]       res_d;
  logic [15:0]       dcmp_d;
  assign acc_adj = acc_q + (acc_q[ProdW-1] ? 36'd255 : 36'd0);
  assign res_div = acc_adj[ProdW-1:8];
  always_comb begin
    priority if (res_div > 28'sd100) begin
      res_d = 16'd100;
    end else if (res_div < 28'sd0 && reverse_q) begin
      res_d = 16'd0;
    end else if (res_div < -28'sd32768) begin
      res_d = 16'h8000;
    end else begin
      res_d = res_div[15:0];
    end
    if (dir_mode_q) begin
      dcmp_d = 16'd0;
    end else if (reverse_q) begin
      dcmp_d = pm1;
    end else begin
      dcmp_d = {5'b00000, prod_q[33:23]};
    end
  end

  // drive = |6000 - 60*|res||, clamped and dead-zoned
  logic [16:0] abs_res;
  logic [22:0] d60, dmag;
  logic [12:0] dclamp, drive_d;
  assign abs_res = res_q[15] ? (17'd0 - {1'b1, res_q}) : {1'b0, res_q};
  assign d60     = {abs_res, 6'b000000} - {4'b0000, abs_res, 2'b00};
  assign dmag    = (d60 >= 23'd6000) ? (d60 - 23'd6000) : (23'd6000 - d60);
  assign dclamp  = (dmag > 23'd6000) ? 13'd6000 : dmag[12:0];
  assign drive_d = (dclamp < dead_zone_q) ? 13'd0 : dclamp;

  // duty = drive*pm1 / 10000 by reciprocal
  logic [58:0] duty_prod;
  logic [15:0] duty_d;
  assign duty_prod = prod_q[28:0] * Recip10k;
  assign duty_d    = duty_prod[58:43];

  // input capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= s_axis_tdata;
      req_q <= s_axis_tuser;
    end
  end

  // loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odo_q      <= '0;
      last_odo_q <= '0;
      integral_q <= '0;
      last_err_q <= '0;
    end else if (step_en) begin
      unique case (cw.dp_op)
        DpSpeed: begin
          if (req_q == ReqHall) begin
            odo_q <= reverse_q ? odo_q - 32'd1 : odo_q + 32'd1;
          end else begin
            last_odo_q <= odo_q;
          end
        end
        DpIntegral: integral_q <= integral_d;
        DpLastErr:  last_err_q <= err_q;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (step_en) begin
      if (cw.mul_sel != MulNone) begin
        prod_q <= mul_p;
      end
      unique case (cw.acc_op)
        AccHold: ;
        AccLoad: acc_q <= prod_q;
        AccAdd:  acc_q <= acc_q + prod_q;
      endcase
      unique case (cw.dp_op)
        DpSpeed:  speed_q  <= speed_d;
        DpTarget: target_q <= target_d;
        DpError:  err_q    <= err_d;
        DpResult: begin
          res_q  <= res_d;
          dcmp_q <= dcmp_d;
        end
        DpDrive:  drive_q  <= drive_d;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en && cw.dp_op == DpEmit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && cw.dp_op == DpEmit) begin
      out_data_q <= {7'd0, res_q, speed_q, dir_mode_q & reverse_q, dcmp_q, duty_d};
    end
  end

endmodule

// ===== sv/hsp_check.sv =====
// port-level checker for the hall speed pid controller, bound to the top level
`include "assert_macros.svh"

module hsp_check (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [hsp_pkg::OutDataW-1:0]  m_axis_tdata
);
  import hsp_pkg::*;

  // one item at a time: busy right after a transaction
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // pid result never above the cap
  `ASSERT_NOW(a_pid_cap, clk_i, rst_ni, m_axis_tvalid, $signed(m_axis_tdata[64:49]) <= 16'sd100, "pid output above cap")

  // level mode and compare mode exclude each other
  `ASSERT_NOW(a_dir_excl, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[32] && m_axis_tdata[31:16] != 16'd0), "dir level with dir compare")

endmodule

bind hall_speed_pid_pwm hsp_check u_hsp_check (.*);

// ===== test/hall_speed_pid_pwm_tb.sv =====
// testbench for hall_speed_pid_pwm: directed table, then random hall/tick runs checked by a predictor
module hall_speed_pid_pwm_tb;
  import hsp_pkg::*;

  localparam logic ReqTick     = 1'b1;
  localparam int   DrainCycles = 16;
  localparam int   EndCycles   = 30;
  localparam int   StallLimit  = 4000;  // no transaction on either side for this long
  localparam int   HoldCycles  = 400;
  localparam int   MaxReports  = 10;

  // one result, laid out as the low bits of m_axis_tdata
  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] speed;
    logic        lvl;
    logic [15:0] dcmp;
    logic [15:0] duty;
  } loop_res_t;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  val;
    logic                 req;
    logic [CmdW-1:0]      cmd;
    bit                   typed;
    loop_res_t            res;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // speed_cmd
  logic                s_axis_tuser = 1'b0; // req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // duty_compare, dir_compare, dir_level, measured_speed, pid_output, zero pad
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  hall_speed_pid_pwm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the registers, reset values
  logic [15:0] g_p = 16'd128;
  logic [15:0] g_i = 16'd512;
  logic [15:0] g_d = 16'd0;
  logic [14:0] int_lim = 15'd150;
  logic [12:0] dz = 13'd40;
  logic [15:0] tmr_period = 16'd1000;
  logic        rev = 1'b0;
  logic        dmode = 1'b0;

  // controller state
  logic [31:0]        odo = '0;
  logic [31:0]        odo_prev = '0;
  logic signed [15:0] integ = '0;
  logic signed [15:0] err_prev = '0;

  loop_res_t pending_res[$];
  int        mism_cnt = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  int        hold_ask = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  // hall edge moves the odometer by the direction
  function automatic void odo_step();
    if (rev) odo = odo - 32'd1;
    else odo = odo + 32'd1;
  endfunction

  // control tick: speed, error, integral, pid and compare values
  function automatic loop_res_t pid_tick(input logic signed [15:0] cmd);
    int          tgt, spd, lim, drive, dzv, pm1, duty, dcmp;
    logic [31:0] dlt, mag;
    longint      e, s, acc, r, a, drv, gp, gi, gd, iv, ep;
    loop_res_t   o;
    tgt = 100 - int'(cmd) / 60;
    dlt = odo - odo_prev;
    mag = dlt[31] ? (32'd0 - dlt) : dlt;
    spd = (mag > 32'd65535) ? 65535 : int'(mag);
    odo_prev = odo;
    e = longint'(tgt) - longint'(spd);
    if (e > 32767) e = 32767;
    else if (e < -32768) e = -32768;
    // integral with symmetric clamp, decay toward zero at rest
    lim = int'(int_lim);
    iv = integ;
    s = iv + e;
    if (s > lim) s = lim;
    else if (s < -lim) s = -lim;
    integ = s[15:0];
    if (tgt == 0 && spd == 0) begin
      if (integ > 0) integ = integ - 16'sd1;
      else if (integ < 0) integ = integ + 16'sd1;
    end
    // exact pid sum, truncated toward zero
    gp = g_p;
    gi = g_i;
    gd = g_d;
    iv = integ;
    ep = err_prev;
    acc = gp * e + gi * iv + gd * (e - ep);
    err_prev = e[15:0];
    r = acc / 256;
    if (r > 100) r = 100;
    if (r < 0 && rev) r = 0;
    if (r < -32768) r = -32768;
    // drive value and compares
    a = (r < 0) ? -r : r;
    drv = 6000 - 60 * a;
    if (drv < 0) drv = -drv;
    if (drv > 6000) drv = 6000;
    drive = int'(drv);
    dzv = int'(dz);
    if (drive < dzv) drive = 0;
    pm1 = (tmr_period > 0) ? int'(tmr_period) - 1 : 0;
    duty = (drive * pm1) / 10000;
    if (!dmode) dcmp = rev ? pm1 : (10 * pm1) / 1000;
    else dcmp = 0;
    o.duty = duty[15:0];
    o.dcmp = dcmp[15:0];
    o.lvl = dmode ? rev : 1'b0;
    o.speed = spd[15:0];
    o.pid = r[15:0];
    return o;
  endfunction

  // wait until every expected result has come and the block has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegGainP:    g_p = val;
      RegGainI:    g_i = val;
      RegGainD:    g_d = val;
      RegIntLimit: int_lim = val[14:0];
      RegDeadZone: dz = val[12:0];
      RegPeriod:   tmr_period = val;
      RegReverse:  rev = val[0];
      RegDirMode:  dmode = val[0];
      default: ;
    endcase
  endtask

  // offer one item, predict on acceptance
  task automatic send_item(input logic req, input logic [CmdW-1:0] cmd,
                           input bit typed, input loop_res_t tres);
    loop_res_t p;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= cmd;
    s_axis_tuser <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    if (req == ReqHall) begin
      odo_step();
    end else begin
      p = pid_tick(cmd);
      pending_res.push_back(typed ? tres : p);
    end
  endtask

  function automatic stim_row_t mk_item(input logic req, input logic [CmdW-1:0] cmd);
    stim_row_t r;
    r = '{kind: RowItem, idx: '0, val: '0, req: req, cmd: cmd, typed: 1'b0, res: '0};
    return r;
  endfunction

  function automatic stim_row_t mk_typed(input logic [CmdW-1:0] cmd, input loop_res_t res);
    stim_row_t r;
    r = '{kind: RowItem, idx: '0, val: '0, req: ReqTick, cmd: cmd, typed: 1'b1, res: res};
    return r;
  endfunction

  function automatic stim_row_t mk_cfg(input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDataW-1:0] val);
    stim_row_t r;
    r = '{kind: RowCfg, idx: idx, val: val, req: ReqHall, cmd: '0, typed: 1'b0, res: '0};
    return r;
  endfunction

  // zero, the top or anything in between
  function automatic logic [CfgDataW-1:0] pick(input int hi);
    int v;
    case ($urandom_range(3))
      0: v = 0;
      1: v = hi;
      default: v = $urandom_range(hi);
    endcase
    return v[CfgDataW-1:0];
  endfunction

  function automatic logic [CmdW-1:0] rand_cmd();
    int v;
    case ($urandom_range(4))
      0: v = $urandom_range(6059, 6000);           // target of zero
      1: v = $urandom_range(6600) - 600;           // moderate targets
      2: v = $urandom_range(1) ? 32767 : -32768;
      default: v = $urandom_range(16'hFFFF);
    endcase
    return v[CmdW-1:0];
  endfunction

  task automatic shuffle_cfg();
    logic [CfgDataW-1:0] per;
    per = ($urandom_range(15) == 0) ? 16'd0 : pick(65535);
    write_reg(RegGainP, pick(65535));
    write_reg(RegGainI, pick(65535));
    write_reg(RegGainD, pick(65535));
    write_reg(RegIntLimit, pick(32767));
    write_reg(RegDeadZone, ($urandom_range(1) == 0) ? pick(6000) : pick(8191));
    write_reg(RegPeriod, per);
    write_reg(RegReverse, 16'($urandom_range(1)));
    write_reg(RegDirMode, 16'($urandom_range(1)));
  endtask

  // result side: random stalls, long hold on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin : res_check
    loop_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(loop_res_t)-1:0];
      if (pending_res.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= MaxReports)
          $display("unexpected result %h at %0t", got, $realtime);
      end else begin
        want = pending_res.pop_front();
        if (got.duty !== want.duty || got.dcmp !== want.dcmp || got.lvl !== want.lvl ||
            got.speed !== want.speed || got.pid !== want.pid) begin
          mism_cnt++;
          if (mism_cnt <= MaxReports)
            $display("mismatch at %0t: duty %0d/%0d dcmp %0d/%0d lvl %0d/%0d speed %0d/%0d pid %0d/%0d",
                     $realtime, want.duty, got.duty, want.dcmp, got.dcmp, want.lvl, got.lvl,
                     want.speed, got.speed, $signed(want.pid), $signed(got.pid));
        end
      end
    end
  end

  // watchdog: cycles without any transaction
  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall = 0;
      else stall++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // stimulus
  initial begin : stim
    stim_row_t dir_tab[$];
    int        k, n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    dir_tab.push_back(mk_typed(16'd0, '{pid: 16'd100, speed: 16'd0, lvl: 1'b0,
                                        dcmp: 16'd9, duty: 16'd0}));
    dir_tab.push_back(mk_item(ReqHall, 16'hFFFF));
    dir_tab.push_back(mk_item(ReqHall, 16'h0000));
    dir_tab.push_back(mk_item(ReqHall, 16'h5555));
    dir_tab.push_back(mk_item(ReqTick, 16'h7FFF));
    dir_tab.push_back(mk_item(ReqTick, 16'h8000));
    dir_tab.push_back(mk_item(ReqTick, 16'd6000));
    dir_tab.push_back(mk_item(ReqTick, 16'hFFFF));
    // counting down through zero wraps the odometer
    dir_tab.push_back(mk_cfg(RegReverse, 16'd1));
    dir_tab.push_back(mk_item(ReqHall, 16'hAAAA));
    dir_tab.push_back(mk_item(ReqHall, 16'h0001));
    dir_tab.push_back(mk_item(ReqHall, 16'h8000));
    dir_tab.push_back(mk_item(ReqHall, 16'h00FF));
    dir_tab.push_back(mk_item(ReqTick, 16'd0));
    dir_tab.push_back(mk_item(ReqTick, 16'd6059));
    // full gains and limit
    dir_tab.push_back(mk_cfg(RegGainP, 16'hFFFF));
    dir_tab.push_back(mk_cfg(RegGainI, 16'hFFFF));
    dir_tab.push_back(mk_cfg(RegGainD, 16'hFFFF));
    dir_tab.push_back(mk_cfg(RegIntLimit, 16'h7FFF));
    dir_tab.push_back(mk_cfg(RegDirMode, 16'd1));
    dir_tab.push_back(mk_item(ReqTick, 16'h8000));
    dir_tab.push_back(mk_item(ReqTick, 16'h7FFF));
    // zero gains give full drive
    dir_tab.push_back(mk_cfg(RegGainP, 16'd0));
    dir_tab.push_back(mk_cfg(RegGainI, 16'd0));
    dir_tab.push_back(mk_cfg(RegGainD, 16'd0));
    dir_tab.push_back(mk_cfg(RegReverse, 16'd0));
    dir_tab.push_back(mk_cfg(RegDirMode, 16'd0));
    dir_tab.push_back(mk_cfg(RegPeriod, 16'd10001));
    dir_tab.push_back(mk_cfg(RegDeadZone, 16'd0));
    dir_tab.push_back(mk_typed(16'd0, '{pid: 16'd0, speed: 16'd0, lvl: 1'b0,
                                        dcmp: 16'd100, duty: 16'd6000}));
    // dead zone above full drive
    dir_tab.push_back(mk_cfg(RegDeadZone, 16'd8191));
    dir_tab.push_back(mk_typed(16'h7FFF, '{pid: 16'd0, speed: 16'd0, lvl: 1'b0,
                                           dcmp: 16'd100, duty: 16'd0}));
    // zero period
    dir_tab.push_back(mk_cfg(RegPeriod, 16'd0));
    dir_tab.push_back(mk_cfg(RegReverse, 16'd1));
    dir_tab.push_back(mk_typed(16'h8000, '{pid: 16'd0, speed: 16'd0, lvl: 1'b0,
                                           dcmp: 16'd0, duty: 16'd0}));
    // back to defaults, widest period
    dir_tab.push_back(mk_cfg(RegGainP, 16'd128));
    dir_tab.push_back(mk_cfg(RegGainI, 16'd512));
    dir_tab.push_back(mk_cfg(RegIntLimit, 16'd150));
    dir_tab.push_back(mk_cfg(RegDeadZone, 16'd40));
    dir_tab.push_back(mk_cfg(RegPeriod, 16'hFFFF));
    dir_tab.push_back(mk_cfg(RegReverse, 16'd0));
    dir_tab.push_back(mk_item(ReqHall, 16'h1234));
    dir_tab.push_back(mk_item(ReqTick, 16'hFDA8));
    dir_tab.push_back(mk_item(ReqTick, 16'd1));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowCfg) write_reg(dir_tab[i].idx, dir_tab[i].val);
      else send_item(dir_tab[i].req, dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);
    end

    // random phases: runs of hall edges, each closed by a control tick
    for (int ph = 0; ph < 8; ph++) begin
      shuffle_cfg();
      if (ph < 3) begin
        src_idle_pct = 33;
        snk_idle_pct = 75;
      end else if (ph < 6) begin
        src_idle_pct = 75;
        snk_idle_pct = 33;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (ph == 2 || ph == 6) hold_ask++;
      if (ph == 7) begin
        // deep negative error at full proportional gain: pid result saturates low
        write_reg(RegReverse, 16'd0);
        write_reg(RegGainP, 16'hFFFF);
        write_reg(RegGainI, 16'd0);
        write_reg(RegGainD, 16'd0);
        for (n = 0; n < 20; n++) send_item(ReqHall, rand_cmd(), 1'b0, '0);
        send_item(ReqTick, 16'h7FFF, 1'b0, '0);
      end
      for (int t = 0; t < 16; t++) begin
        k = ($urandom_range(11) == 0) ? $urandom_range(120, 30) : $urandom_range(6);
        for (n = 0; n < k; n++) send_item(ReqHall, rand_cmd(), 1'b0, '0);
        send_item(ReqTick, rand_cmd(), 1'b0, '0);
      end
    end

    settle();
    repeat (EndCycles) @(posedge clk_i);
    if (mism_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
